/* sv/agc_pkg.sv */
package agc_pkg;

    // Field widths of one word on either side.
    localparam int FONT_W   = 16;
    localparam int CODE_W   = 16;
    localparam int GLYPH_W  = 16;
    localparam int META_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 2;
    localparam int S_DATA_W = FONT_W + CODE_W + GLYPH_W + META_W;
    localparam int M_FIELDS_W = 1 + GLYPH_W + META_W + SLOT_W;
    localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    // Operation carried in s_tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_CODE   = 2'd0,
        KIND_INDEX  = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic search_step;
        logic victim_write;
        logic push;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_search;
        logic scan_last;
        logic out_busy;
    } dp_status_t;

endpackage

/* sv/agc_ctrl.sv */
module agc_ctrl
    import agc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        s_tready         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.need_search) begin
                    state_next = ST_SEARCH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.victim_write = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/agc_dp.sv */
module agc_dp
    import agc_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int AGE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

    // Latched input word.
    kind_t              kind_reg;
    logic [FONT_W-1:0]  font_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [GLYPH_W-1:0] glyph_reg;
    logic [META_W-1:0]  meta_reg;

    // Entry storage, one compare lane per entry.
    logic [FONT_W-1:0]   ent_font_reg  [ENTRIES];
    logic [CODE_W-1:0]   ent_code_reg  [ENTRIES];
    logic [GLYPH_W-1:0]  ent_glyph_reg [ENTRIES];
    logic [META_W-1:0]   ent_meta_reg  [ENTRIES];
    logic [AGE_BITS-1:0] ent_age_reg   [ENTRIES];
    logic [FW-1:0]       fill_reg;

    // Victim search.
    logic [IW-1:0]       scan_reg;
    logic [IW-1:0]       best_reg;
    logic [AGE_BITS-1:0] best_age_reg;

    // Pending result and output register.
    logic               res_hit_reg;
    logic [GLYPH_W-1:0] res_idx_reg;
    logic [META_W-1:0]  res_meta_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [GLYPH_W-1:0] out_idx_reg;
    logic [META_W-1:0]  out_meta_reg;
    logic [SLOT_W-1:0]  out_slot_reg;

    logic [ENTRIES-1:0] valid;
    logic [ENTRIES-1:0] code_match;
    logic [ENTRIES-1:0] gidx_match;
    logic [IW-1:0]      code_hit_idx;
    logic [IW-1:0]      gidx_hit_idx;
    logic               full;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [AGE_BITS-1:0] scan_age;

    assign full = (fill_reg == FW'(ENTRIES));

    // Parallel compare of every entry against the latched key.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            valid[i]      = (FW'(i) < fill_reg);
            code_match[i] = valid[i] && (ent_font_reg[i] == font_reg)
                            && (ent_code_reg[i] == code_reg);
            gidx_match[i] = valid[i] && (ent_font_reg[i] == font_reg)
                            && (ent_glyph_reg[i] == glyph_reg);
        end
    end

    // Highest code match and lowest index match.
    always_comb begin
        code_hit_idx = '0;
        gidx_hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (code_match[i]) begin
                code_hit_idx = IW'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (gidx_match[i]) begin
                gidx_hit_idx = IW'(i);
            end
        end
    end

    // An insert goes to the next free slot, or to the victim once full.
    assign wr_en   = (cmd.exec && kind_reg == KIND_INSERT && !full) || cmd.victim_write;
    assign wr_addr = cmd.victim_write ? best_reg : fill_reg[IW-1:0];
    assign scan_age = ent_age_reg[scan_reg];

    assign status.need_search = (kind_reg == KIND_INSERT) && full;
    assign status.scan_last   = (scan_reg == IW'(ENTRIES - 1));
    assign status.out_busy    = out_valid_reg && !m_tready;

    // Input word capture.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= kind_t'(s_tuser);
            font_reg  <= s_tdata[FONT_W-1:0];
            code_reg  <= s_tdata[FONT_W+CODE_W-1:FONT_W];
            glyph_reg <= s_tdata[FONT_W+CODE_W+GLYPH_W-1:FONT_W+CODE_W];
            meta_reg  <= s_tdata[S_DATA_W-1:FONT_W+CODE_W+GLYPH_W];
        end
    end

    // Entry updates: aging on a code lookup, field writes on an insert.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (cmd.exec && kind_reg == KIND_CODE && valid[i]) begin
                ent_age_reg[i] <= (ent_age_reg[i] >> 1) | (code_match[i] ? AGE_TOP : '0);
            end
            if (wr_en && wr_addr == IW'(i)) begin
                ent_font_reg[i]  <= font_reg;
                ent_code_reg[i]  <= code_reg;
                ent_glyph_reg[i] <= glyph_reg;
                ent_meta_reg[i]  <= meta_reg;
                ent_age_reg[i]   <= AGE_TOP;
            end
        end
    end

    // Fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.exec && kind_reg == KIND_CLEAR) begin
            fill_reg <= '0;
        end else if (cmd.exec && kind_reg == KIND_INSERT && !full) begin
            fill_reg <= fill_reg + FW'(1);
        end
    end

    // Least-age search, one entry per cycle; ties keep the lower slot.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            scan_reg     <= IW'(1);
            best_reg     <= '0;
            best_age_reg <= ent_age_reg[0];
        end else if (cmd.search_step) begin
            scan_reg <= scan_reg + IW'(1);
            if (scan_age < best_age_reg) begin
                best_reg     <= scan_reg;
                best_age_reg <= scan_age;
            end
        end
    end

    // Pending result.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_hit_reg  <= 1'b0;
            res_idx_reg  <= '0;
            res_meta_reg <= '0;
            res_slot_reg <= '0;
            case (kind_reg)
                KIND_CODE: begin
                    if (|code_match) begin
                        res_hit_reg  <= 1'b1;
                        res_idx_reg  <= ent_glyph_reg[code_hit_idx];
                        res_slot_reg <= SLOT_W'(code_hit_idx);
                    end
                end
                KIND_INDEX: begin
                    if (|gidx_match) begin
                        res_hit_reg  <= 1'b1;
                        res_meta_reg <= ent_meta_reg[gidx_hit_idx];
                        res_slot_reg <= SLOT_W'(gidx_hit_idx);
                    end
                end
                KIND_INSERT: begin
                    res_slot_reg <= SLOT_W'(fill_reg);
                end
                default: begin
                end
            endcase
        end else if (cmd.victim_write) begin
            res_slot_reg <= SLOT_W'(best_reg);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_hit_reg  <= res_hit_reg;
            out_idx_reg  <= res_idx_reg;
            out_meta_reg <= res_meta_reg;
            out_slot_reg <= res_slot_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - M_FIELDS_W)'(0), out_slot_reg, out_meta_reg,
                       out_idx_reg, out_hit_reg};

    // The fill count never passes the entry count.
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(ENTRIES))
        else $error("fill count above entry count");

    // A victim is only written when every slot is in use.
    a_victim_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.victim_write |-> full)
        else $error("victim write while cache not full");

    // Lookups leave the fill count alone.
    a_lookup_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && (kind_reg == KIND_CODE || kind_reg == KIND_INDEX) |=> $stable(fill_reg))
        else $error("lookup changed fill count");

    // An insert into a cache with room grows it by one.
    a_insert_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && kind_reg == KIND_INSERT && !full |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("insert did not grow fill count");

    // A pushed result is presented in the next cycle.
    a_push_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> out_valid_reg)
        else $error("pushed result not presented");

endmodule

/* sv/aging_glyph_cache_core.sv */
// Channel  Dir  Ports                     Contents
// s_       in   tvalid tready tdata tuser one request word: kind, key and metadata
// m_       out  tvalid tready tdata       one result word per request
//
// A lookup, a clear or an insert with a free slot passes the states EXEC and DONE
// from accept to the next accept. An insert into a full cache scans the ages one
// entry per cycle in SEARCH and then writes the victim in WRITE before DONE.
// Reset (aresetn low at a clock edge) empties the cache and drops any result.
// One request is in work at a time; a new one is taken while the last result
// still waits in the output register, which holds it under m_tready low.
module aging_glyph_cache_core
    import agc_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int AGE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // font, code, glyph_index, meta_in
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // hit, index_out, meta_out, slot
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    agc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    agc_dp #(
        .ENTRIES  (ENTRIES),
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* tb/aging_glyph_cache_core_test.sv */
`timescale 1ns / 100ps

module aging_glyph_cache_core_test;
    import agc_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_ITEMS = 1280;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int HIST_DEPTH   = 32;
    localparam logic [31:0] AGE_TOP = 32'h8000_0000;

    // One result word, split into its fields.
    typedef struct packed {
        logic                hit;
        logic [GLYPH_W-1:0]  glyph;
        logic [META_W-1:0]   meta;
        logic [SLOT_W-1:0]   slot;
    } glyph_result_t;

    // Tracks the cache contents and keeps the results that are still owed.
    class glyph_cache_scoreboard;
        logic [FONT_W-1:0]  font_tbl[NUM_SLOTS];
        logic [CODE_W-1:0]  code_tbl[NUM_SLOTS];
        logic [GLYPH_W-1:0] glyph_tbl[NUM_SLOTS];
        logic [META_W-1:0]  meta_tbl[NUM_SLOTS];
        logic [31:0]        age_tbl[NUM_SLOTS];
        int unsigned        valid_count;
        glyph_result_t      owed_q[$];
        int unsigned        mismatches;
        int unsigned        results_seen;
        int unsigned        hits;
        int unsigned        evictions;
        int unsigned        clears;

        function void note_request(input kind_t k, input logic [FONT_W-1:0] f,
                                   input logic [CODE_W-1:0] c, input logic [GLYPH_W-1:0] g,
                                   input logic [META_W-1:0] m);
            glyph_result_t r;
            int unsigned   victim;
            r = '0;
            case (k)
                KIND_CODE: begin
                    // Every valid entry ages; matches get refreshed, the last one wins.
                    for (int i = 0; i < valid_count; i++) begin
                        age_tbl[i] = age_tbl[i] >> 1;
                        if (font_tbl[i] == f && code_tbl[i] == c) begin
                            age_tbl[i] = age_tbl[i] | AGE_TOP;
                            r.hit   = 1'b1;
                            r.glyph = glyph_tbl[i];
                            r.slot  = i[SLOT_W-1:0];
                        end
                    end
                end
                KIND_INDEX: begin
                    // The first matching entry answers; ages stay as they are.
                    for (int i = 0; i < valid_count; i++) begin
                        if (!r.hit && font_tbl[i] == f && glyph_tbl[i] == g) begin
                            r.hit  = 1'b1;
                            r.meta = meta_tbl[i];
                            r.slot = i[SLOT_W-1:0];
                        end
                    end
                end
                KIND_INSERT: begin
                    if (valid_count < NUM_SLOTS) begin
                        victim = valid_count;
                        valid_count++;
                    end else begin
                        // Full: the lowest-numbered entry of least age is replaced.
                        victim = 0;
                        for (int i = 1; i < NUM_SLOTS; i++)
                            if (age_tbl[i] < age_tbl[victim])
                                victim = i;
                        evictions++;
                    end
                    age_tbl[victim]   = AGE_TOP;
                    font_tbl[victim]  = f;
                    code_tbl[victim]  = c;
                    glyph_tbl[victim] = g;
                    meta_tbl[victim]  = m;
                    r.slot = victim[SLOT_W-1:0];
                end
                default: begin
                    valid_count = 0;
                    clears++;
                end
            endcase
            if (r.hit)
                hits++;
            owed_q.push_back(r);
        endfunction

        function void check_result(input logic [M_DATA_W-1:0] word);
            glyph_result_t got;
            glyph_result_t want;
            got.hit   = word[0];
            got.glyph = word[GLYPH_W:1];
            got.meta  = word[GLYPH_W+META_W:GLYPH_W+1];
            got.slot  = word[GLYPH_W+META_W+SLOT_W:GLYPH_W+META_W+1];
            results_seen++;
            if (owed_q.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result with none owed: hit=%0d glyph=%h meta=%h slot=%0d",
                             $time, got.hit, got.glyph, got.meta, got.slot);
                mismatches++;
            end else begin
                want = owed_q.pop_front();
                if (got.hit != want.hit || got.glyph != want.glyph ||
                    got.meta != want.meta || got.slot != want.slot) begin
                    if (mismatches < 10)
                        $display("%0t: result %0d: expected hit=%0d glyph=%h meta=%h slot=%0d, %s",
                                 $time, results_seen, want.hit, want.glyph, want.meta,
                                 want.slot,
                                 $sformatf("got hit=%0d glyph=%h meta=%h slot=%0d",
                                           got.hit, got.glyph, got.meta, got.slot));
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = KIND_CODE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    glyph_cache_scoreboard sb = new();

    int unsigned cycle_count       = 0;
    int unsigned requests_sent     = 0;
    int unsigned burst_left        = 0;
    bit          bulk_phase        = 1'b0;
    bit          long_hold_done    = 1'b0;
    int unsigned bulk_phase_cycles = 0;
    int unsigned hold_left         = 0;
    int unsigned sink_tick         = 0;
    int unsigned sink_mode         = 0;

    // Key pools keep the random traffic hitting the cache.
    logic [FONT_W-1:0]  font_pool[4];
    logic [CODE_W-1:0]  code_pool[8];
    logic [GLYPH_W-1:0] glyph_pool[8];
    logic [FONT_W-1:0]  hist_font[HIST_DEPTH];
    logic [CODE_W-1:0]  hist_code[HIST_DEPTH];
    logic [GLYPH_W-1:0] hist_glyph[HIST_DEPTH];
    int unsigned        hist_count = 0;
    int unsigned        hist_wr    = 0;

    aging_glyph_cache_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle counter and watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results still owed.",
                     cycle_count, sb.owed_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result check on every accepted word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver stall pattern, with one long hold-off early in the random phase.
    always @(negedge aclk) begin
        if (bulk_phase && !long_hold_done && bulk_phase_cycles == 40) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (bulk_phase)
            bulk_phase_cycles++;
        if (sink_tick % 48 == 0)
            sink_mode = $urandom_range(0, 3);
        sink_tick++;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (sink_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= sink_tick[2];
            endcase
        end
    end

    // Offers one word and waits for it to be taken; bursts end in a random gap.
    task automatic send_request(input kind_t k, input logic [FONT_W-1:0] f,
                                input logic [CODE_W-1:0] c, input logic [GLYPH_W-1:0] g,
                                input logic [META_W-1:0] m);
        int unsigned gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {m, g, c, f};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(k, f, c, g, m);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
    endtask

    // Extremes of the fields, each operation and the corner cases of the cache.
    task automatic run_directed();
        send_request(KIND_CLEAR, 16'h1111, 16'h2222, 16'h3333, 32'h4444_4444);
        send_request(KIND_CODE, '0, '0, '0, '0);
        send_request(KIND_INDEX, '1, '1, '1, '1);
        // Fill all slots with no lookups in between, so every age is equal.
        send_request(KIND_INSERT, '0, '0, '0, '0);
        send_request(KIND_INSERT, '1, '1, '1, '1);
        send_request(KIND_INSERT, '0, '0, 16'h0007, 32'hA5A5_A5A5);
        for (int i = 3; i < NUM_SLOTS; i++)
            send_request(KIND_INSERT, FONT_W'(16'h0100 + i), CODE_W'($urandom),
                         GLYPH_W'($urandom), $urandom);
        // Full cache with equal ages: the replacement lands in slot 0.
        send_request(KIND_INSERT, '0, '0, 16'h0007, 32'h5A5A_5A5A);
        // Two code matches: the higher slot answers. Two index matches: the lower one.
        send_request(KIND_CODE, '0, '0, 16'hFFFF, '1);
        send_request(KIND_INDEX, '0, 16'hFFFF, 16'h0007, '0);
        send_request(KIND_CODE, '1, '1, '0, '0);
        send_request(KIND_INDEX, '1, '0, '1, '0);
        send_request(KIND_CODE, 16'h0001, '0, '0, '0);
        send_request(KIND_CLEAR, '1, '1, '1, '1);
        send_request(KIND_CODE, '0, '0, '0, '0);
    endtask

    // Mostly lookups of keys inserted recently, with some random noise.
    task automatic run_random(input int unsigned count);
        kind_t              k;
        logic [FONT_W-1:0]  f;
        logic [CODE_W-1:0]  c;
        logic [GLYPH_W-1:0] g;
        logic [META_W-1:0]  m;
        int unsigned        pick;
        int unsigned        h;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                k = KIND_CODE;
            else if (pick < 65)
                k = KIND_INDEX;
            else if (pick < 99)
                k = KIND_INSERT;
            else
                k = KIND_CLEAR;
            f = font_pool[$urandom_range(0, 3)];
            c = code_pool[$urandom_range(0, 7)];
            g = ($urandom_range(0, 9) < 6) ? glyph_pool[$urandom_range(0, 7)]
                                           : GLYPH_W'($urandom);
            m = $urandom;
            if ($urandom_range(0, 9) == 0) begin
                f = FONT_W'($urandom);
                c = CODE_W'($urandom);
            end
            if (k != KIND_INSERT && hist_count > 0 && $urandom_range(0, 9) < 7) begin
                h = $urandom_range(0, hist_count - 1);
                f = hist_font[h];
                c = hist_code[h];
                g = hist_glyph[h];
            end
            if (k == KIND_INSERT) begin
                hist_font[hist_wr]  = f;
                hist_code[hist_wr]  = c;
                hist_glyph[hist_wr] = g;
                hist_wr = (hist_wr + 1) % HIST_DEPTH;
                if (hist_count < HIST_DEPTH)
                    hist_count++;
            end
            send_request(k, f, c, g, m);
        end
    endtask

    // Main sequence: reset, directed part, random part, drain and verdict.
    initial begin
        font_pool[0] = '0;
        font_pool[1] = '1;
        font_pool[2] = FONT_W'($urandom);
        font_pool[3] = FONT_W'($urandom);
        for (int i = 0; i < 8; i++) begin
            code_pool[i]  = CODE_W'($urandom);
            glyph_pool[i] = GLYPH_W'($urandom);
        end
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        bulk_phase = 1'b1;
        run_random(RANDOM_ITEMS);
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.owed_q.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);

        $display("Sent %0d requests, checked %0d results: %0d lookup hits, %0d clears.",
                 requests_sent, sb.results_seen, sb.hits, sb.clears);
        $display("Full-cache replacements: %0d; long receiver hold-off of %0d cycles done.",
                 sb.evictions, LONG_HOLD);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches.", sb.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
